// ===== rtl/crt_pkg.sv =====
// Package for the cellular rule table: sizes, item kinds, status codes and
// the per-cell control struct. No dependencies.
`timescale 1ns / 1ps
package crt_pkg;
  localparam int ENTRIES    = 64;
  localparam int MAX_STATES = 16;
  localparam int MASK_BITS  = 32;
  localparam int SW = 4;   // state field width
  localparam int IW = 32;  // mask port width
  localparam int EW = $clog2(ENTRIES);

  localparam logic [2:0] K_SET    = 3'd0;
  localparam logic [2:0] K_LOOKUP = 3'd1;
  localparam logic [2:0] K_REMOVE = 3'd2;
  localparam logic [2:0] K_REKEY  = 3'd3;
  localparam logic [2:0] K_REKEYS = 3'd4;
  localparam logic [2:0] K_SETFB  = 3'd5;
  localparam logic [2:0] K_GETFB  = 3'd6;
  localparam logic [2:0] K_UNUSED = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BAD  = 2'd3;

  // Broadcast from the controller to every cell during the compare beat.
  typedef struct packed {
    logic [SW-1:0]        owner;
    logic [MASK_BITS-1:0] key;
    logic [MASK_BITS-1:0] nkey;
  } crt_cmp_t;

  // Write commands applied in the decide cycle; each cell uses its own
  // select bit from the controller.
  typedef struct packed {
    logic            alloc;    // selected cell becomes valid with owner/key
    logic            clear;    // selected cell drops its rule
    logic            wr_key;   // selected cell takes nkey
    logic            wr_next;  // selected cell takes next
    logic [SW-1:0]   owner;
    logic [MASK_BITS-1:0] key;
    logic [MASK_BITS-1:0] nkey;
    logic [SW-1:0]   next;
  } crt_wr_t;
endpackage

// ===== rtl/cellular_rule_table_core.sv =====
// Cellular automaton rule table, top level. Depends on crt_pkg, crt_cell.
// Capture registers the input beat; the cycle after capture does the compare,
//   the slot update and the answer, all taken at its end edge.
// Input stalls during the decide cycle, so no new item is taken before the
//   last is decided, and also while a finished result waits under out_stall.
// Reset (rst_n, synchronous): all slots invalid, fallbacks zero,
//   total_states = 2. Slot contents are not cleared.
`timescale 1ns / 1ps
module cellular_rule_table_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_total_states,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [3:0]  in_cell_state,
  input  logic [31:0] in_mask,
  input  logic [31:0] in_new_mask,
  input  logic [3:0]  in_new_state,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_result_state,
  output logic        out_hit
);
  import crt_pkg::*;

  // Two-phase control: busy_r marks the item captured and being decided.
  logic          busy_r;
  logic [2:0]    kind_r;
  logic [SW-1:0] cs_r, ns_r;
  logic [MASK_BITS-1:0] key_r, nkey_r;
  logic [4:0]    tot_r;
  logic [SW-1:0] fb_r [MAX_STATES];
  logic          ov_r;
  logic [1:0]    ost_r;
  logic [SW-1:0] ores_r;
  logic          ohit_r;

  crt_cmp_t cmp;
  crt_wr_t  wr;
  logic [ENTRIES-1:0] sel, ffree, hk, hn;
  logic [ENTRIES:0]   fchain;
  logic [SW-1:0]      nxt [ENTRIES];

  // Capture only when the result slot will be free at the decide beat.
  logic take;
  assign in_stall = busy_r | (ov_r & out_stall);
  assign take = in_valid & ~in_stall;

  assign cmp.owner = cs_r;
  assign cmp.key   = key_r;
  assign cmp.nkey  = nkey_r;
  assign fchain[0] = 1'b0;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      crt_cell u_cell (
        .clk(clk), .rst_n(rst_n), .cmp(cmp), .wr(wr), .sel(sel[g]),
        .free_in(fchain[g]), .free_out(fchain[g+1]), .first_free(ffree[g]),
        .hit_key(hk[g]), .hit_nkey(hn[g]), .next(nxt[g])
      );
    end
  endgenerate

  // Matching rule's next state (keys are unique per owner: OR-reduce).
  logic [SW-1:0] hit_next;
  always_comb begin
    hit_next = '0;
    for (int i = 0; i < ENTRIES; i++)
      if (hk[i]) hit_next = hit_next | nxt[i];
  end

  logic any_k, any_n, any_free, cs_ok, ns_ok, need_ns, self_n;
  assign any_k    = |hk;
  assign any_n    = |hn;
  assign self_n   = |(hk & hn);
  assign any_free = fchain[ENTRIES];
  assign cs_ok = {1'b0, cs_r} < tot_r;
  assign ns_ok = {1'b0, ns_r} < tot_r;
  assign need_ns = kind_r == K_SET || kind_r == K_REKEYS || kind_r == K_SETFB;

  logic [1:0]    st;
  logic [SW-1:0] res;
  logic          hitb, fb_we;

  always_comb begin
    wr = '0;
    wr.owner = cs_r; wr.key = key_r; wr.nkey = nkey_r; wr.next = ns_r;
    sel = hk;
    st = ST_OK; res = '0; hitb = 1'b0; fb_we = 1'b0;
    if (kind_r == K_UNUSED) begin
      st = ST_OK;
    end else if (!cs_ok || (need_ns && !ns_ok)) begin
      st = ST_BAD;
    end else begin
      case (kind_r)
        K_SET: begin
          if (any_k) begin
            wr.wr_next = 1'b1;
          end else if (any_free) begin
            sel = ffree; wr.alloc = 1'b1; wr.wr_next = 1'b1;
          end else begin
            st = ST_FULL;
          end
        end
        K_LOOKUP: begin
          hitb = any_k;
          res = any_k ? hit_next : fb_r[cs_r];
        end
        K_REMOVE: begin
          if (any_k) wr.clear = 1'b1;
          else st = ST_MISS;
        end
        K_REKEY, K_REKEYS: begin
          if (!any_k) st = ST_MISS;
          else if (any_n && !self_n) wr.clear = 1'b1;
          else begin
            wr.wr_key = 1'b1;
            wr.wr_next = kind_r == K_REKEYS;
          end
        end
        K_SETFB: fb_we = 1'b1;
        default: res = fb_r[cs_r];
      endcase
    end
    if (!busy_r) begin
      wr.alloc = 1'b0; wr.clear = 1'b0; wr.wr_key = 1'b0; wr.wr_next = 1'b0;
      fb_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
      tot_r  <= 5'd2;
      for (int i = 0; i < MAX_STATES; i++) fb_r[i] <= '0;
    end else begin
      if (cfg_we) tot_r <= cfg_total_states;
      if (fb_we) fb_r[cs_r] <= ns_r;
      if (busy_r) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      busy_r <= take;
    end
    if (take) begin
      kind_r <= in_kind; cs_r <= in_cell_state; ns_r <= in_new_state;
      key_r  <= in_mask[MASK_BITS-1:0]; nkey_r <= in_new_mask[MASK_BITS-1:0];
    end
    if (busy_r) begin
      ost_r <= st; ores_r <= res; ohit_r <= hitb;
    end
  end

  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_result_state = ores_r;
  assign out_hit = ohit_r;
endmodule

// ===== rtl/crt_cell.sv =====
// One rule slot: valid bit, owner, key and next state, with match flags.
// Hands a "free seen" chain bit to its neighbor. Depends on crt_pkg.
`timescale 1ns / 1ps
module crt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  crt_pkg::crt_cmp_t cmp,
  input  crt_pkg::crt_wr_t  wr,
  input  logic              sel,
  input  logic              free_in,   // a lower slot is free
  output logic              free_out,
  output logic              first_free,
  output logic              hit_key,
  output logic              hit_nkey,
  output logic [crt_pkg::SW-1:0] next
);
  import crt_pkg::*;
  logic valid_r, valid_nxt;
  logic [SW-1:0] owner_r, next_r;
  logic [MASK_BITS-1:0] key_r;

  assign free_out   = free_in | ~valid_r;
  assign first_free = ~valid_r & ~free_in;
  assign hit_key  = valid_r && owner_r == cmp.owner && key_r == cmp.key;
  assign hit_nkey = valid_r && owner_r == cmp.owner && key_r == cmp.nkey;
  assign next = next_r;

  always_comb begin
    valid_nxt = valid_r;
    if (sel && wr.alloc) valid_nxt = 1'b1;
    if (sel && wr.clear) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
    if (sel && wr.alloc) begin
      owner_r <= wr.owner;
      key_r   <= wr.key;
    end
    if (sel && wr.wr_key) key_r <= wr.nkey;
    if (sel && wr.wr_next) next_r <= wr.next;
  end
endmodule

// ===== sim/tb_cellular_rule_table_core.sv =====
// Testbench for cellular_rule_table_core: random and directed rule-table
// beats checked against an in-bench table predictor. Depends on crt_pkg.
`timescale 1ns / 1ps
module tb_cellular_rule_table_core;
  import crt_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  cs;
    logic [31:0] mask;
    logic [31:0] nmask;
    logic [3:0]  ns;
  } rule_op_t;

  typedef struct {
    logic [1:0] status;
    logic [3:0] res;
    logic       hit;
  } rule_ans_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_total_states = 5'd2;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = '0;
  logic [3:0]  in_cell_state = '0;
  logic [31:0] in_mask = '0;
  logic [31:0] in_new_mask = '0;
  logic [3:0]  in_new_state = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_result_state;
  logic        out_hit;

  cellular_rule_table_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  bit          tbl_valid [ENTRIES];
  logic [3:0]  tbl_owner [ENTRIES];
  logic [31:0] tbl_key   [ENTRIES];
  logic [3:0]  tbl_next  [ENTRIES];
  logic [3:0]  tbl_fb    [MAX_STATES];
  int unsigned n_states = 2;

  rule_op_t  pending_ops[$];
  rule_ans_t expected_ans[$];
  int  errors = 0;
  bit  idle_off = 0;      // no random idling in the final part
  int  hold_off = 0;      // long receiver hold-off, counted in the monitor
  bit  src_pause = 0;
  longint cycles = 0;

  function automatic bit state_ok(logic [3:0] s);
    return s < n_states;
  endfunction

  function automatic int find_rule(logic [3:0] o, logic [31:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (tbl_valid[i] && tbl_owner[i] == o && tbl_key[i] == k) return i;
    return -1;
  endfunction

  // apply one beat to the predictor, return its answer
  function automatic rule_ans_t rule_update(rule_op_t op);
    rule_ans_t a;
    int s, t;
    a = '{ST_OK, 4'd0, 1'b0};
    if (op.kind == K_UNUSED) return a;
    if (!state_ok(op.cs) || ((op.kind == K_SET || op.kind == K_REKEYS ||
        op.kind == K_SETFB) && !state_ok(op.ns))) begin
      a.status = ST_BAD;
      return a;
    end
    s = find_rule(op.cs, op.mask);
    case (op.kind)
      K_SET: begin
        if (s < 0) begin
          for (int i = 0; i < ENTRIES && s < 0; i++) if (!tbl_valid[i]) s = i;
          if (s < 0) begin
            a.status = ST_FULL;
            return a;
          end
          tbl_valid[s] = 1; tbl_owner[s] = op.cs; tbl_key[s] = op.mask;
        end
        tbl_next[s] = op.ns;
      end
      K_LOOKUP: begin
        if (s >= 0) begin
          a.res = tbl_next[s]; a.hit = 1'b1;
        end else a.res = tbl_fb[op.cs];
      end
      K_REMOVE: begin
        if (s < 0) a.status = ST_MISS;
        else tbl_valid[s] = 0;
      end
      K_REKEY, K_REKEYS: begin
        if (s < 0) a.status = ST_MISS;
        else begin
          t = find_rule(op.cs, op.nmask);
          if (t >= 0 && t != s) tbl_valid[s] = 0;
          else begin
            tbl_key[s] = op.nmask;
            if (op.kind == K_REKEYS) tbl_next[s] = op.ns;
          end
        end
      end
      K_SETFB: tbl_fb[op.cs] = op.ns;
      default: a.res = tbl_fb[op.cs];
    endcase
    return a;
  endfunction

  // driver: one beat at a time from pending_ops, random idle bursts
  int src_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_ans.push_back(rule_update(pending_ops.pop_front()));
        if (!idle_off && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 9);
      end
      if (src_gap > 0 && !(in_valid && !in_stall)) src_gap <= src_gap - 1;
      // valid only moves when the current beat is gone or none is up;
      // an accepted beat has already left the queue, so the head is next
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() > 0 && !src_pause &&
            src_gap == 0 && !(in_valid && !in_stall && !idle_off &&
            $urandom_range(0, 9) == 0)) begin
          rule_op_t nx;
          nx = pending_ops[0];
          in_valid <= 1'b1;
          in_kind <= nx.kind; in_cell_state <= nx.cs; in_mask <= nx.mask;
          in_new_mask <= nx.nmask; in_new_state <= nx.ns;
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks each result beat, drives out_stall
  int sink_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_ans.size() == 0) begin
          $error("result beat with no expectation");
          errors++;
        end else begin
          rule_ans_t e;
          e = expected_ans.pop_front();
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); errors++;
          end
          if (out_result_state !== e.res) begin
            $error("result_state exp %0d got %0d", e.res, out_result_state); errors++;
          end
          if (out_hit !== e.hit) begin
            $error("hit exp %0d got %0d", e.hit, out_hit); errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_stall <= 1'b1;
      end else if (!idle_off && $urandom_range(0, 11) == 0) begin
        sink_gap <= $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  always @(posedge clk)
    if (cycles > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end

  task automatic push_op(logic [2:0] k, logic [3:0] c, logic [31:0] m,
                         logic [31:0] nm, logic [3:0] n);
    pending_ops.push_back('{k, c, m, nm, n});
  endtask

  task automatic drain();
    wait (pending_ops.size() == 0 && expected_ans.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_states(logic [4:0] v);
    drain();
    cfg_total_states <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_states = v;
  endtask

  // random beats; small key pool so rules collide, rekey and fill up
  task automatic random_ops(int n, int kmax);
    logic [31:0] pool [8];
    pool = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0001, 32'h1, 32'h5A5A_A5A5,
             32'h7FFF_FFFE, 32'h0000_0100, 32'hDEAD_BEEF};
    for (int i = 0; i < n; i++) begin
      logic [31:0] m, nm;
      m  = ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, kmax)];
      nm = ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, kmax)];
      push_op(3'($urandom_range(0, 7)),
              4'($urandom_range(0, n_states + 1 > 15 ? 15 : n_states + 1)),
              m, nm, 4'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    foreach (tbl_valid[i]) tbl_valid[i] = 0;
    foreach (tbl_fb[i]) tbl_fb[i] = 4'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every kind, bad states, miss, rekey cases at reset setting
    push_op(K_LOOKUP, 0, 32'h0, 32'h0, 0);
    push_op(K_SET, 1, 32'hFFFF_FFFF, 32'h0, 1);
    push_op(K_SET, 1, 32'hFFFF_FFFF, 32'h0, 0);       // overwrite
    push_op(K_LOOKUP, 1, 32'hFFFF_FFFF, 32'h0, 0);
    push_op(K_SET, 2, 32'h1, 32'h0, 0);               // bad cell state
    push_op(K_SET, 0, 32'h1, 32'h0, 15);              // bad new state
    push_op(K_SETFB, 1, 32'h0, 32'h0, 1);
    push_op(K_GETFB, 1, 32'h0, 32'h0, 0);
    push_op(K_LOOKUP, 1, 32'h1234, 32'h0, 0);         // fallback answer
    push_op(K_REMOVE, 0, 32'h55, 32'h0, 0);           // missing key
    push_op(K_SET, 1, 32'h10, 32'h0, 0);
    push_op(K_REKEY, 1, 32'h10, 32'hFFFF_FFFF, 0);    // onto existing key
    push_op(K_LOOKUP, 1, 32'h10, 32'h0, 0);
    push_op(K_REKEYS, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1); // onto own key
    push_op(K_REKEYS, 1, 32'hFFFF_FFFF, 32'h8000_0000, 0);
    push_op(K_REKEY, 1, 32'h99, 32'h1, 0);            // missing key
    push_op(K_LOOKUP, 1, 32'h8000_0000, 32'h0, 0);
    push_op(K_UNUSED, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15);
    push_op(K_REMOVE, 1, 32'h8000_0000, 32'h0, 0);
    set_states(5'd16);
    push_op(K_SET, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15);
    push_op(K_SETFB, 15, 32'h0, 32'h0, 15);
    push_op(K_GETFB, 15, 32'h0, 32'h0, 0);
    // fill the store to force a full status
    for (int i = 0; i < ENTRIES + 2; i++)
      push_op(K_SET, 4'(i % 16), 32'(i), 32'h0, 4'(i % 16));
    push_op(K_LOOKUP, 15, 32'hFFFF_FFFF, 32'h0, 0);
    set_states(5'd1);
    random_ops(150, 7);
    set_states(5'd16);
    for (int i = 0; i < ENTRIES; i++) push_op(K_REMOVE, 4'(i % 16), 32'(i), 32'h0, 0);
    random_ops(250, 7);

    // receiver holds off while sender keeps offering
    wait (expected_ans.size() == 0);
    hold_off = 300;
    random_ops(40, 3);
    drain();
    set_states(5'd3);
    random_ops(300, 3);
    // sender pause until all answers are in
    wait (pending_ops.size() == 0);
    src_pause = 1;
    wait (expected_ans.size() == 0);
    src_pause = 0;
    set_states(5'd0);
    random_ops(40, 3);
    set_states(5'd9);
    random_ops(300, 7);
    drain();
    idle_off = 1;
    random_ops(150, 3);

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
